>>> rtl/core/assert_macros.svh
// Assertion helpers used by the checker file lsf_checker.sv.
// Every assertion is clocked on the rising edge and is off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define CHK_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed in %m");

// Checks that a condition is followed by a consequence on the next edge.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed in %m");

`endif

>>> rtl/core/lsf_pkg.sv
`default_nettype none

package lsf_pkg;

	// Default sizes.
	localparam int PATTERN_BYTES_DEF = 32;
	localparam int MAX_LINES_DEF     = 65535;

	// Configuration port.
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SELECT  = 3'd6;

	localparam int PATTERN_LENGTH_W = 6;

	// Byte codes.
	localparam logic [7:0] NEWLINE_BYTE  = 8'd10;
	localparam logic [7:0] ASCII_UPPER_A = 8'd65;
	localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
	localparam logic [7:0] CASE_OFFSET   = 8'd32;

	// Saturation point of the line and hit counters.
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_buffer;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] line_number;
		logic        selected;
		logic        buffer_done;
		logic [15:0] hit_count;
	} out_beat_t;

	// Folds ASCII upper case to lower case when enabled.
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
		logic [7:0] r;
		r = b;
		if (fold_en && (b inside {[ASCII_UPPER_A:ASCII_UPPER_Z]})) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/lsf_stream_if.sv
`default_nettype none

// Valid/ready stream carrying one payload beat.
interface lsf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/line_substring_filter.sv
// Line substring filter.
// in_ch carries text beats (text_byte, end_of_buffer), one byte per beat. A newline
// byte or a beat with end_of_buffer ends a line; a newline that also ends the buffer
// ends only that one line. out_ch carries one beat per line end: line_number,
// selected, buffer_done and the running hit_count of the buffer.
// The pattern, its length, case folding and inversion are set on the write port
// (cfg_we, cfg_index, cfg_data); the user must set them only while the stream is
// idle, since the block itself does not enforce it. Throughput is one byte per cycle
// unless out_ch stalls: the whole pattern is compared against a window of the most
// recent bytes in one pass, straight from the byte held in the input register. A
// line-ending byte passes through the input register and then the result register
// before its result shows on out_ch. A byte that ends no line never waits on out_ch.
// When out_ch stalls with a result pending, the next line-ending byte holds in the
// input register and in_ch.ready drops until the pending beat is taken.
// Reset clears the configuration, the counters and both stages; the byte window
// needs no clearing, since only bytes of the current line are ever compared.
`default_nettype none

module line_substring_filter #(
	parameter int PATTERN_BYTES = lsf_pkg::PATTERN_BYTES_DEF,
	parameter int MAX_LINES     = lsf_pkg::MAX_LINES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsf_pkg::CFG_DATA_W-1:0] cfg_data,
	lsf_stream_if.sink                          in_ch,
	lsf_stream_if.source                        out_ch
);

	localparam int LW = $clog2(PATTERN_BYTES + 1);
	localparam int IW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

	// Configuration registers.
	logic [7:0]                         pat_q [PATTERN_BYTES];
	logic [lsf_pkg::PATTERN_LENGTH_W-1:0] len_cfg_q;
	logic                               fold_q;
	logic                               invert_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Line state.
	logic [7:0]  win_q [PATTERN_BYTES];
	logic [LW-1:0] cnt_q;
	logic        matched_q;
	logic [15:0] lines_q;
	logic [15:0] hits_q;

	// Result register.
	logic                 out_valid_q;
	lsf_pkg::out_beat_t   out_q;

	// Per-byte logic.
	logic [7:0]    win_new [PATTERN_BYTES];
	logic [LW-1:0] used_len;
	logic [LW-1:0] cnt_new;
	logic [PATTERN_BYTES-1:0] lane_ok;
	logic          hit;
	logic          is_nl;
	logic          emit;
	logic          matched_new;
	logic          found;
	logic          in_limit;
	logic          sel;
	logic [15:0]   num;
	logic [15:0]   hits_new;
	logic          stall;
	logic          go;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_BYTES; k++) begin
				pat_q[k] <= '0;
			end
			len_cfg_q <= '0;
			fold_q    <= 1'b0;
			invert_q  <= 1'b0;
		end else if (cfg_we) begin
			for (int k = 0; k < PATTERN_BYTES; k++) begin
				if (cfg_index == lsf_pkg::CFG_IDX_W'(lsf_pkg::CFG_PATTERN_WORD0 + (k >> 3))) begin
					pat_q[k] <= cfg_data[(k & 7) * 8 +: 8];
				end
			end
			if (cfg_index == lsf_pkg::CFG_PATTERN_LENGTH) begin
				len_cfg_q <= cfg_data[lsf_pkg::PATTERN_LENGTH_W-1:0];
			end
			if (cfg_index == lsf_pkg::CFG_IGNORE_CASE) begin
				fold_q <= cfg_data[0];
			end
			if (cfg_index == lsf_pkg::CFG_INVERT_SELECT) begin
				invert_q <= cfg_data[0];
			end
		end
	end

	// Lengths above the window size act as the window size.
	assign used_len = (len_cfg_q > lsf_pkg::PATTERN_LENGTH_W'(PATTERN_BYTES)) ?
		LW'(PATTERN_BYTES) : len_cfg_q[LW-1:0];

	// A line-ending byte waits while an earlier result is still held.
	assign is_nl = (byte_s1 == lsf_pkg::NEWLINE_BYTE);
	assign emit  = is_nl || last_s1;
	assign stall = valid_s1 && emit && out_valid_q && !out_ch.ready;
	assign go    = valid_s1 && !stall;
	assign in_ch.ready = !stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (!stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data.text_byte;
			last_s1 <= in_ch.data.end_of_buffer;
		end
	end

	// Window with the new byte shifted in at the newest end.
	always_comb begin
		win_new[0] = byte_s1;
		for (int j = 1; j < PATTERN_BYTES; j++) begin
			win_new[j] = win_q[j-1];
		end
	end

	assign cnt_new = (cnt_q == LW'(PATTERN_BYTES)) ? cnt_q : cnt_q + LW'(1);

	// Pattern byte k lines up with the window byte len-1-k; lanes past the length pass.
	always_comb begin
		logic [LW-1:0] idx;
		for (int k = 0; k < PATTERN_BYTES; k++) begin
			idx = used_len - LW'(k + 1);
			if (LW'(k) < used_len) begin
				lane_ok[k] = (lsf_pkg::fold_byte(pat_q[k], fold_q) ==
					lsf_pkg::fold_byte(win_new[idx[IW-1:0]], fold_q));
			end else begin
				lane_ok[k] = 1'b1;
			end
		end
	end

	assign hit = (used_len != '0) && (cnt_new >= used_len) && (&lane_ok);

	// Line end decision.
	assign matched_new = is_nl ? matched_q : (matched_q || hit);
	assign found       = (used_len == '0) || matched_new;
	assign in_limit    = (lines_q < 16'(MAX_LINES));
	assign sel         = in_limit && (found != invert_q);
	assign num         = (lines_q != lsf_pkg::COUNT_MAX) ? lines_q + 16'd1 : lines_q;
	assign hits_new    = (sel && (hits_q != lsf_pkg::COUNT_MAX)) ? hits_q + 16'd1 : hits_q;

	// Window storage; a newline is not part of any line.
	always_ff @(posedge clk) begin
		if (go && !is_nl) begin
			for (int j = 0; j < PATTERN_BYTES; j++) begin
				win_q[j] <= win_new[j];
			end
		end
	end

	// Line and buffer counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			matched_q <= 1'b0;
			lines_q   <= '0;
			hits_q    <= '0;
		end else if (go) begin
			if (emit) begin
				cnt_q     <= '0;
				matched_q <= 1'b0;
				lines_q   <= last_s1 ? 16'd0 : num;
				hits_q    <= last_s1 ? 16'd0 : hits_new;
			end else begin
				cnt_q     <= cnt_new;
				matched_q <= matched_new;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_q.line_number <= num;
			out_q.selected    <= sel;
			out_q.buffer_done <= last_s1;
			out_q.hit_count   <= hits_new;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/lsf_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lsf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] line_number,
	input wire logic        selected,
	input wire logic        buffer_done,
	input wire logic [15:0] hit_count
);

	logic        prev_done_q;
	logic [15:0] prev_line_q;
	logic [15:0] prev_hit_q;
	logic [15:0] exp_line;
	logic [15:0] exp_hit;
	logic [15:0] hit_base;

	// Remember the last delivered beat of the output stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_done_q <= 1'b1;
			prev_line_q <= '0;
			prev_hit_q  <= '0;
		end else if (out_valid && out_ready) begin
			prev_done_q <= buffer_done;
			prev_line_q <= line_number;
			prev_hit_q  <= hit_count;
		end
	end

	// Expected numbering: a new buffer starts at line one, counters saturate.
	always_comb begin
		hit_base = prev_done_q ? 16'd0 : prev_hit_q;
		if (prev_done_q) begin
			exp_line = 16'd1;
		end else if (prev_line_q == lsf_pkg::COUNT_MAX) begin
			exp_line = prev_line_q;
		end else begin
			exp_line = prev_line_q + 16'd1;
		end
		if (selected && (hit_base != lsf_pkg::COUNT_MAX)) begin
			exp_hit = hit_base + 16'd1;
		end else begin
			exp_hit = hit_base;
		end
	end

	`CHK_NEXT(a_out_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`CHK_NEXT(a_out_data_hold, clk, arst_n, out_valid && !out_ready, $stable(line_number) && $stable(selected) && $stable(buffer_done) && $stable(hit_count))
	`CHK_ASSERT(a_line_sequence, clk, arst_n, !out_valid || (line_number == exp_line))
	`CHK_ASSERT(a_hit_sequence, clk, arst_n, !out_valid || (hit_count == exp_hit))

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.line_number (out_ch.data.line_number),
	.selected    (out_ch.data.selected),
	.buffer_done (out_ch.data.buffer_done),
	.hit_count   (out_ch.data.hit_count)
);

`default_nettype wire
